[rtl/kvsi_pkg.sv]
package kvsi_pkg;

    // field widths
    localparam int POS_W   = 24;
    localparam int ROOM_W  = 7;
    localparam int WIN_W   = 6;
    localparam int RATIO_W = 13;
    localparam int CAP_W   = 6;
    localparam int SLOT_W  = 6;
    localparam int CNT_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // parameter defaults
    localparam int MAX_WINDOW_DEF     = 32;
    localparam int MAX_COMPRESSED_DEF = 32;
    localparam int POSITION_BITS_DEF  = 24;

    // list room saturates here
    localparam logic [ROOM_W-1:0] ROOM_MAX = 7'd64;

    // request types
    localparam logic [1:0] REQ_WIN_PUT  = 2'd0;
    localparam logic [1:0] REQ_COMP_PUT = 2'd1;
    localparam logic [1:0] REQ_LIST     = 2'd2;

    // result status codes
    localparam logic [1:0] STS_OK           = 2'd0;
    localparam logic [1:0] STS_NOT_BOUNDARY = 2'd1;
    localparam logic [1:0] STS_BEYOND_CAP   = 2'd2;
    localparam logic [1:0] STS_ROOM_SMALL   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SLOTS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESS_RATIO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED_SLOTS = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [POS_W-1:0]  position;
        logic [ROOM_W-1:0] room;
    } req_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot_index;
        logic              slot_empty;
        logic [CNT_W-1:0]  entry_count;
        logic              last;
    } rsp_item_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_win;
        logic list_init;
        logic emit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       div_done;
        logic       out_free;
        logic       single;
        logic       list_last;
        logic [1:0] req_type;
    } dp_status_t;

endpackage

[rtl/kvsi_ctrl.sv]
module kvsi_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic [1:0]             req_type,
    output logic                   req_stall,
    output kvsi_pkg::ctrl_cmd_t    cmd,
    input  kvsi_pkg::dp_status_t   sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_RATIO,
        ST_DIV_WIN,
        ST_DECIDE,
        ST_EMIT_ONE,
        ST_LIST
    } state_t;

    state_t state_reg;
    state_t state_next;

    // one item at a time
    assign req_stall = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    case (req_type) inside
                        kvsi_pkg::REQ_WIN_PUT:
                        begin
                            cmd.div_start = 1'b1;
                            cmd.div_win   = 1'b1;
                            state_next    = ST_DIV_WIN;
                        end
                        kvsi_pkg::REQ_COMP_PUT, kvsi_pkg::REQ_LIST:
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIV_RATIO;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV_RATIO:
            begin
                if (sts.div_done)
                begin
                    if (sts.req_type == kvsi_pkg::REQ_LIST)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_win   = 1'b1;
                        state_next    = ST_DIV_WIN;
                    end
                    else
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DIV_WIN:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (sts.single)
                begin
                    state_next = ST_EMIT_ONE;
                end
                else
                begin
                    cmd.list_init = 1'b1;
                    state_next    = ST_LIST;
                end
            end
            ST_EMIT_ONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LIST:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.list_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/kvsi_datapath.sv]
module kvsi_datapath #(
    parameter int POSITION_BITS = kvsi_pkg::POSITION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kvsi_pkg::req_item_t               req,
    input  kvsi_pkg::ctrl_cmd_t               cmd,
    output kvsi_pkg::dp_status_t              sts,
    input  logic [kvsi_pkg::WIN_W-1:0]        win_slots,
    input  logic [kvsi_pkg::RATIO_W-1:0]      ratio,
    input  logic [kvsi_pkg::CAP_W-1:0]        cap,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output kvsi_pkg::rsp_item_t               rsp
);

    localparam int PW = (POSITION_BITS < kvsi_pkg::POS_W) ? POSITION_BITS : kvsi_pkg::POS_W;
    localparam int DW = PW + 1;
    localparam int CW = $clog2(DW);
    localparam int RW = kvsi_pkg::RATIO_W;

    // captured request
    logic [1:0]                  req_type_reg;
    logic [DW-1:0]               next_reg;
    logic [kvsi_pkg::ROOM_W-1:0] room_reg;
    logic [DW-1:0]               next_in;
    logic [kvsi_pkg::ROOM_W-1:0] room_sat;

    // divider
    logic          div_run_reg;
    logic [CW-1:0] cnt_reg;
    logic          sel_win_reg;
    logic [RW-1:0] dvsr_reg;
    logic [RW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [RW:0]   div_trial;
    logic [RW:0]   div_diff;
    logic          div_ge;
    logic [RW-1:0] rem_step;
    logic [DW-1:0] quo_step;
    logic          div_last;

    // division results
    logic                       rzero_reg;
    logic                       over_reg;
    logic [kvsi_pkg::CAP_W-1:0] filled_reg;
    logic [kvsi_pkg::WIN_W-1:0] wrem_reg;

    // list walk
    logic [kvsi_pkg::CNT_W-1:0]  k_reg;
    logic [kvsi_pkg::WIN_W-1:0]  ring_reg;
    logic [kvsi_pkg::CNT_W-1:0]  total;
    logic                        room_short;
    logic                        single;
    logic                        short_win;
    logic                        in_win;
    logic                        used;
    logic                        list_last;
    logic [kvsi_pkg::WIN_W-1:0]  ring_inc;

    // output register
    logic                rsp_valid_reg;
    kvsi_pkg::rsp_item_t rsp_reg;
    kvsi_pkg::rsp_item_t rsp_next;
    logic                out_free;
    logic [kvsi_pkg::CNT_W-1:0] put_slot;

    // incoming item: masked position plus one, saturated room
    assign next_in  = {1'b0, req.position[PW-1:0]} + DW'(1);
    assign room_sat = (req.room > kvsi_pkg::ROOM_MAX) ? kvsi_pkg::ROOM_MAX : req.room;

    // restoring divider step, one quotient bit per cycle
    assign div_trial = {rem_reg, quo_reg[DW-1]};
    assign div_diff  = div_trial - {1'b0, dvsr_reg};
    assign div_ge    = (div_trial >= {1'b0, dvsr_reg});
    assign rem_step  = div_ge ? div_diff[RW-1:0] : div_trial[RW-1:0];
    assign quo_step  = {quo_reg[DW-2:0], div_ge};
    assign div_last  = div_run_reg && (cnt_reg == CW'(DW - 1));

    // list bookkeeping
    assign total      = {1'b0, win_slots} + {1'b0, filled_reg};
    assign room_short = (room_reg < total);
    assign single     = (req_type_reg != kvsi_pkg::REQ_LIST) || over_reg || room_short;
    assign short_win  = (next_reg < DW'(win_slots));
    assign in_win     = (k_reg < {1'b0, win_slots});
    assign used       = (DW'(k_reg) < next_reg);
    assign list_last  = ((k_reg + 7'd1) == total);
    assign ring_inc   = (ring_reg == (win_slots - 6'd1)) ? '0 : (ring_reg + 6'd1);
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    // compressed put slot, window plus slot number
    assign put_slot = {1'b0, win_slots} + {1'b0, filled_reg} - 7'd1;

    // result item being loaded
    always_comb
    begin
        rsp_next             = '0;
        rsp_next.last        = 1'b1;
        if (single)
        begin
            case (req_type_reg)
                kvsi_pkg::REQ_WIN_PUT:
                begin
                    rsp_next.status     = kvsi_pkg::STS_OK;
                    rsp_next.slot_index = (wrem_reg == '0) ? (win_slots - 6'd1)
                                                           : (wrem_reg - 6'd1);
                end
                kvsi_pkg::REQ_COMP_PUT:
                begin
                    if (!rzero_reg)
                    begin
                        rsp_next.status = kvsi_pkg::STS_NOT_BOUNDARY;
                    end
                    else if (over_reg)
                    begin
                        rsp_next.status = kvsi_pkg::STS_BEYOND_CAP;
                    end
                    else
                    begin
                        rsp_next.status     = kvsi_pkg::STS_OK;
                        rsp_next.slot_index = put_slot[kvsi_pkg::SLOT_W-1:0];
                    end
                end
                default:
                begin
                    rsp_next.status = over_reg ? kvsi_pkg::STS_BEYOND_CAP
                                               : kvsi_pkg::STS_ROOM_SMALL;
                end
            endcase
        end
        else
        begin
            rsp_next.status      = kvsi_pkg::STS_OK;
            rsp_next.entry_count = total;
            rsp_next.last        = list_last;
            if (in_win && short_win)
            begin
                rsp_next.slot_index = used ? k_reg[kvsi_pkg::SLOT_W-1:0] : '0;
                rsp_next.slot_empty = !used;
            end
            else if (in_win)
            begin
                rsp_next.slot_index = ring_reg;
            end
            else
            begin
                rsp_next.slot_index = k_reg[kvsi_pkg::SLOT_W-1:0];
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_run_reg   <= 1'b0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.div_start)
            begin
                div_run_reg <= 1'b1;
                cnt_reg     <= '0;
            end
            else if (div_run_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (div_last)
                begin
                    div_run_reg <= 1'b0;
                end
            end
            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        // request capture
        if (cmd.capture)
        begin
            req_type_reg <= req.req_type;
            next_reg     <= next_in;
            room_reg     <= room_sat;
        end
        // divider load and step
        if (cmd.div_start)
        begin
            sel_win_reg <= cmd.div_win;
            dvsr_reg    <= cmd.div_win ? RW'(win_slots) : ratio;
            rem_reg     <= '0;
            quo_reg     <= cmd.capture ? next_in : next_reg;
        end
        else if (div_run_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
        end
        // keep results of the finished division
        if (div_last)
        begin
            if (sel_win_reg)
            begin
                wrem_reg <= rem_step[kvsi_pkg::WIN_W-1:0];
            end
            else
            begin
                rzero_reg  <= (rem_step == '0);
                over_reg   <= (quo_step > DW'(cap));
                filled_reg <= quo_step[kvsi_pkg::CAP_W-1:0];
            end
        end
        // list walk
        if (cmd.list_init)
        begin
            k_reg    <= '0;
            ring_reg <= wrem_reg;
        end
        else if (cmd.emit)
        begin
            k_reg <= k_reg + 7'd1;
            if (in_win)
            begin
                ring_reg <= ring_inc;
            end
        end
        if (cmd.emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign sts.div_done  = div_last;
    assign sts.out_free  = out_free;
    assign sts.single    = single;
    assign sts.list_last = list_last;
    assign sts.req_type  = req_type_reg;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/kv_cache_slot_indexer.sv]
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | kvsi_pkg::req_item_t
// rsp     | out       | rsp_valid/rsp_stall | kvsi_pkg::rsp_item_t
// cfg     | in        | cfg_wr_en           | cfg_index, cfg_data
//
// one item at a time; a shared restoring divider gives one bit per cycle
// over min(POSITION_BITS, 24)+1 steps (25 at the default width)
// a put gives a single result; a list gives one entry per slot (up to 64),
// a rejected list a single error item
// the next item is taken once the final result sits in the output register
// rsp_stall holds the output register and the list walk; reset is async, low
module kv_cache_slot_indexer #(
    parameter int MAX_WINDOW     = kvsi_pkg::MAX_WINDOW_DEF,
    parameter int MAX_COMPRESSED = kvsi_pkg::MAX_COMPRESSED_DEF,
    parameter int POSITION_BITS  = kvsi_pkg::POSITION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  kvsi_pkg::req_item_t                 req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output kvsi_pkg::rsp_item_t                 rsp,
    input  logic                                cfg_wr_en,
    input  logic [kvsi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kvsi_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [kvsi_pkg::WIN_W-1:0]   win_slots_reg;
    logic [kvsi_pkg::RATIO_W-1:0] ratio_reg;
    logic [kvsi_pkg::CAP_W-1:0]   cap_reg;
    logic [kvsi_pkg::WIN_W-1:0]   eff_win;
    logic [kvsi_pkg::RATIO_W-1:0] eff_ratio;
    logic [kvsi_pkg::CAP_W-1:0]   eff_cap;

    kvsi_pkg::ctrl_cmd_t  cmd;
    kvsi_pkg::dp_status_t sts;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_slots_reg <= 6'd32;
            ratio_reg     <= 13'd4;
            cap_reg       <= 6'd32;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                kvsi_pkg::CFG_WINDOW_SLOTS:
                begin
                    win_slots_reg <= cfg_data[kvsi_pkg::WIN_W-1:0];
                end
                kvsi_pkg::CFG_COMPRESS_RATIO:
                begin
                    ratio_reg <= cfg_data[kvsi_pkg::RATIO_W-1:0];
                end
                kvsi_pkg::CFG_COMPRESSED_SLOTS:
                begin
                    cap_reg <= cfg_data[kvsi_pkg::CAP_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // clamp registers into their working range
    always_comb
    begin
        if (win_slots_reg == '0)
        begin
            eff_win = 6'd1;
        end
        else if (win_slots_reg > kvsi_pkg::WIN_W'(MAX_WINDOW))
        begin
            eff_win = kvsi_pkg::WIN_W'(MAX_WINDOW);
        end
        else
        begin
            eff_win = win_slots_reg;
        end
        if (cap_reg == '0)
        begin
            eff_cap = 6'd1;
        end
        else if (cap_reg > kvsi_pkg::CAP_W'(MAX_COMPRESSED))
        begin
            eff_cap = kvsi_pkg::CAP_W'(MAX_COMPRESSED);
        end
        else
        begin
            eff_cap = cap_reg;
        end
        eff_ratio = (ratio_reg == '0) ? 13'd1 : ratio_reg;
    end

    kvsi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    kvsi_datapath #(
        .POSITION_BITS (POSITION_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .win_slots (eff_win),
        .ratio     (eff_ratio),
        .cap       (eff_cap),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // a real request keeps the input side busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (req.req_type == kvsi_pkg::REQ_WIN_PUT ||
         req.req_type == kvsi_pkg::REQ_COMP_PUT || req.req_type == kvsi_pkg::REQ_LIST))
        |=> req_stall)
        else $error("request accepted without going busy");

    // error results stand alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != kvsi_pkg::STS_OK)
        |-> (rsp.last && rsp.entry_count == '0 && rsp.slot_index == '0))
        else $error("error item is not a single closing item");

    // empty window slots carry slot zero inside a list
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.slot_empty)
        |-> (rsp.slot_index == '0 && rsp.entry_count != '0))
        else $error("empty slot item malformed");

endmodule

[dv/tb_kv_cache_slot_indexer.sv]
module tb_kv_cache_slot_indexer;

    timeunit 1ns;
    timeprecision 1ps;

    // request type that the block drops without a result
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // register index that maps to no register
    localparam logic [kvsi_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int ITEMS_PER_PHASE = 21;
    localparam int N_ROWS          = 21;
    localparam int N_FIXED_CFG     = 5;
    localparam int N_PHASES        = 7;
    // long enough for a list to finish, an ignored item leaves no trace
    localparam int SETTLE_CYCLES   = 150;

    localparam kvsi_pkg::rsp_item_t ERR_BOUNDARY =
        '{kvsi_pkg::STS_NOT_BOUNDARY, 6'd0, 1'b0, 7'd0, 1'b1};
    localparam kvsi_pkg::rsp_item_t ERR_CAP =
        '{kvsi_pkg::STS_BEYOND_CAP, 6'd0, 1'b0, 7'd0, 1'b1};
    localparam kvsi_pkg::rsp_item_t ERR_ROOM =
        '{kvsi_pkg::STS_ROOM_SMALL, 6'd0, 1'b0, 7'd0, 1'b1};

    typedef enum logic [1:0] {ROW_FIXED, ROW_PREDICT, ROW_NONE} row_kind_t;

    typedef struct {
        kvsi_pkg::req_item_t cmd;
        row_kind_t           kind;
        kvsi_pkg::rsp_item_t want;
    } row_t;

    typedef struct {
        logic [kvsi_pkg::CFG_DATA_W-1:0] win;
        logic [kvsi_pkg::CFG_DATA_W-1:0] ratio;
        logic [kvsi_pkg::CFG_DATA_W-1:0] cap;
    } setting_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    kvsi_pkg::req_item_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    kvsi_pkg::rsp_item_t rsp;
    logic cfg_wr_en = 1'b0;
    logic [kvsi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [kvsi_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // register copies, reset values of the block
    logic [kvsi_pkg::WIN_W-1:0]   win_reg = 6'd32;
    logic [kvsi_pkg::RATIO_W-1:0] ratio_reg = 13'd4;
    logic [kvsi_pkg::CAP_W-1:0]   cap_reg = 6'd32;

    kvsi_pkg::rsp_item_t slot_queue [$];
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned items_ignored = 0;
    int unsigned results_seen = 0;
    int unsigned list_entries = 0;
    int unsigned error_results = 0;
    int unsigned stall_left = 0;
    bit calm_send = 1'b0;
    bit calm_recv = 1'b0;

    // directed items under the reset settings: ring 32, ratio 4, capacity 32
    row_t rows [N_ROWS] = '{
        '{'{kvsi_pkg::REQ_WIN_PUT, 24'd0, 7'd0}, ROW_FIXED,
          '{kvsi_pkg::STS_OK, 6'd0, 1'b0, 7'd0, 1'b1}},
        '{'{kvsi_pkg::REQ_WIN_PUT, 24'hFFFFFF, 7'd127}, ROW_FIXED,
          '{kvsi_pkg::STS_OK, 6'd31, 1'b0, 7'd0, 1'b1}},
        '{'{kvsi_pkg::REQ_WIN_PUT, 24'd33, 7'd64}, ROW_FIXED,
          '{kvsi_pkg::STS_OK, 6'd1, 1'b0, 7'd0, 1'b1}},
        '{'{kvsi_pkg::REQ_WIN_PUT, 24'h5A5A5A, 7'd21}, ROW_PREDICT, '0},
        '{'{kvsi_pkg::REQ_COMP_PUT, 24'd3, 7'd0}, ROW_FIXED,
          '{kvsi_pkg::STS_OK, 6'd32, 1'b0, 7'd0, 1'b1}},
        '{'{kvsi_pkg::REQ_COMP_PUT, 24'd0, 7'd0}, ROW_FIXED, ERR_BOUNDARY},
        '{'{kvsi_pkg::REQ_COMP_PUT, 24'd127, 7'd0}, ROW_FIXED,
          '{kvsi_pkg::STS_OK, 6'd63, 1'b0, 7'd0, 1'b1}},
        '{'{kvsi_pkg::REQ_COMP_PUT, 24'd131, 7'd0}, ROW_FIXED, ERR_CAP},
        '{'{kvsi_pkg::REQ_COMP_PUT, 24'hFFFFFF, 7'd127}, ROW_FIXED, ERR_CAP},
        '{'{kvsi_pkg::REQ_LIST, 24'd0, 7'd127}, ROW_PREDICT, '0},
        '{'{kvsi_pkg::REQ_LIST, 24'd0, 7'd64}, ROW_PREDICT, '0},
        '{'{kvsi_pkg::REQ_LIST, 24'd0, 7'd31}, ROW_FIXED, ERR_ROOM},
        '{'{kvsi_pkg::REQ_LIST, 24'd0, 7'd0}, ROW_FIXED, ERR_ROOM},
        '{'{kvsi_pkg::REQ_LIST, 24'd30, 7'd64}, ROW_PREDICT, '0},
        '{'{kvsi_pkg::REQ_LIST, 24'd31, 7'd64}, ROW_PREDICT, '0},
        '{'{kvsi_pkg::REQ_LIST, 24'd127, 7'd64}, ROW_PREDICT, '0},
        '{'{kvsi_pkg::REQ_LIST, 24'd127, 7'd63}, ROW_FIXED, ERR_ROOM},
        '{'{kvsi_pkg::REQ_LIST, 24'd131, 7'd64}, ROW_FIXED, ERR_CAP},
        '{'{kvsi_pkg::REQ_LIST, 24'hFFFFFF, 7'd127}, ROW_FIXED, ERR_CAP},
        '{'{REQ_UNUSED, 24'hFFFFFF, 7'd127}, ROW_NONE, '0},
        '{'{kvsi_pkg::REQ_LIST, 24'd100, 7'd100}, ROW_PREDICT, '0}
    };

    // smallest, largest, zero and over-range register values
    setting_t fixed_cfg [N_FIXED_CFG] = '{
        '{13'd1, 13'd1, 13'd1},
        '{13'd32, 13'd4096, 13'd32},
        '{13'h1FC0, 13'd0, 13'h0FC0},
        '{13'd63, 13'd8191, 13'd63},
        '{13'h1FFF, 13'd3, 13'd5}
    };

    kv_cache_slot_indexer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5ns clk = ~clk;

    // effective register values after clamping
    function automatic int unsigned eff_win();
        if (win_reg == 0)
            return 1;
        return (win_reg > kvsi_pkg::MAX_WINDOW_DEF) ? kvsi_pkg::MAX_WINDOW_DEF : win_reg;
    endfunction

    function automatic int unsigned eff_ratio();
        return (ratio_reg == 0) ? 1 : ratio_reg;
    endfunction

    function automatic int unsigned eff_cap();
        if (cap_reg == 0)
            return 1;
        return (cap_reg > kvsi_pkg::MAX_COMPRESSED_DEF) ? kvsi_pkg::MAX_COMPRESSED_DEF
                                                        : cap_reg;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic kvsi_pkg::rsp_item_t slot_rsp(logic [1:0] st, int unsigned slot,
                                                     bit empty, int unsigned cnt, bit fin);
        kvsi_pkg::rsp_item_t r;
        r.status      = st;
        r.slot_index  = kvsi_pkg::SLOT_W'(slot);
        r.slot_empty  = empty;
        r.entry_count = kvsi_pkg::CNT_W'(cnt);
        r.last        = fin;
        return r;
    endfunction

    // slot numbers and attention order for one accepted item
    task automatic compute_slots(input kvsi_pkg::req_item_t it);
        int unsigned w;
        int unsigned ratio;
        int unsigned cap;
        int unsigned room;
        int unsigned nxt;
        int unsigned filled;
        int unsigned total;
        int unsigned oldest;
        int unsigned k;
        bit fin;
        w     = eff_win();
        ratio = eff_ratio();
        cap   = eff_cap();
        room  = (it.room > kvsi_pkg::ROOM_MAX) ? kvsi_pkg::ROOM_MAX : it.room;
        nxt   = it.position + 1;
        case (it.req_type)
            kvsi_pkg::REQ_WIN_PUT:
                slot_queue.push_back(slot_rsp(kvsi_pkg::STS_OK, it.position % w, 1'b0, 0,
                                              1'b1));
            kvsi_pkg::REQ_COMP_PUT:
            begin
                if (nxt % ratio != 0)
                    slot_queue.push_back(ERR_BOUNDARY);
                else if (nxt / ratio - 1 >= cap)
                    slot_queue.push_back(ERR_CAP);
                else
                    slot_queue.push_back(slot_rsp(kvsi_pkg::STS_OK, w + nxt / ratio - 1,
                                                  1'b0, 0, 1'b1));
            end
            kvsi_pkg::REQ_LIST:
            begin
                filled = nxt / ratio;
                total  = w + filled;
                oldest = nxt % w;
                if (filled > cap)
                    slot_queue.push_back(ERR_CAP);
                else if (room < total)
                    slot_queue.push_back(ERR_ROOM);
                else
                begin
                    // ring slots oldest first, then compressed slots in order
                    for (k = 0; k < total; k++)
                    begin
                        fin = (k + 1 == total);
                        if (k >= w)
                            slot_queue.push_back(slot_rsp(kvsi_pkg::STS_OK, k, 1'b0, total,
                                                          fin));
                        else if (nxt < w)
                            slot_queue.push_back(slot_rsp(kvsi_pkg::STS_OK,
                                                          (k <= it.position) ? k : 0,
                                                          k > it.position, total, fin));
                        else
                            slot_queue.push_back(slot_rsp(kvsi_pkg::STS_OK, (oldest + k) % w,
                                                          1'b0, total, fin));
                    end
                end
            end
            default: ;
        endcase
    endtask

    // random item shaped by the current settings
    function automatic kvsi_pkg::req_item_t pick_request();
        kvsi_pkg::req_item_t it;
        int unsigned w;
        int unsigned ratio;
        int unsigned cap;
        int unsigned pick;
        int unsigned filled;
        int unsigned total;
        w     = eff_win();
        ratio = eff_ratio();
        cap   = eff_cap();
        pick  = $urandom_range(0, 99);
        it.room     = kvsi_pkg::ROOM_W'($urandom_range(0, 127));
        it.position = kvsi_pkg::POS_W'($urandom);
        if (pick < 20)
        begin
            it.req_type = kvsi_pkg::REQ_WIN_PUT;
            if (pick < 5)
                it.position = kvsi_pkg::POS_W'($urandom_range(0, 2 * w));
        end
        else if (pick < 40)
        begin
            // mostly boundaries, a few just past capacity
            it.req_type = kvsi_pkg::REQ_COMP_PUT;
            if (pick < 36)
                it.position = kvsi_pkg::POS_W'($urandom_range(1, cap + 2) * ratio - 1);
        end
        else if (pick < 92)
        begin
            it.req_type = kvsi_pkg::REQ_LIST;
            if (pick < 56)
                it.position = kvsi_pkg::POS_W'($urandom_range(0, w - 1));
            else
            begin
                filled = (pick >= 90) ? cap + 1 : $urandom_range(0, cap);
                it.position = kvsi_pkg::POS_W'(filled * ratio + $urandom_range(0, ratio - 1));
            end
            total = w + (it.position + 1) / ratio;
            if (total <= kvsi_pkg::ROOM_MAX && $urandom_range(0, 4) != 0)
                it.room = kvsi_pkg::ROOM_W'($urandom_range(total, 127));
        end
        else if (pick < 97)
            it.req_type = 2'($urandom_range(kvsi_pkg::REQ_WIN_PUT, kvsi_pkg::REQ_LIST));
        else
            it.req_type = REQ_UNUSED;
        return it;
    endfunction

    // present one item and hold it until taken
    task automatic issue(input kvsi_pkg::req_item_t it);
        req       <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (it.req_type == REQ_UNUSED)
            items_ignored++;
        else
            items_sent++;
    endtask

    task automatic pause();
        int unsigned n;
        n = calm_send ? 0 : gap_len();
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // hold off until every pending result is back and the block has settled
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (slot_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [kvsi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [kvsi_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            kvsi_pkg::CFG_WINDOW_SLOTS:     win_reg = val[kvsi_pkg::WIN_W-1:0];
            kvsi_pkg::CFG_COMPRESS_RATIO:   ratio_reg = val[kvsi_pkg::RATIO_W-1:0];
            kvsi_pkg::CFG_COMPRESSED_SLOTS: cap_reg = val[kvsi_pkg::CAP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input setting_t s);
        write_reg(kvsi_pkg::CFG_WINDOW_SLOTS, s.win);
        write_reg(kvsi_pkg::CFG_COMPRESS_RATIO, s.ratio);
        write_reg(kvsi_pkg::CFG_COMPRESSED_SLOTS, s.cap);
        write_reg(CFG_UNUSED, kvsi_pkg::CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_slot(input kvsi_pkg::rsp_item_t got);
        kvsi_pkg::rsp_item_t want;
        results_seen++;
        if (slot_queue.size() == 0)
        begin
            $error("result with nothing pending: %p", got);
            mismatches++;
        end
        else
        begin
            want = slot_queue.pop_front();
            if (want.status != kvsi_pkg::STS_OK)
                error_results++;
            else if (want.entry_count != 0)
                list_entries++;
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.slot_index !== want.slot_index)
            begin
                $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
                mismatches++;
            end
            if (got.slot_empty !== want.slot_empty)
            begin
                $error("slot_empty: expected %0d, got %0d", want.slot_empty, got.slot_empty);
                mismatches++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", want.entry_count,
                       got.entry_count);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
        end
    endtask

    // result side: check taken items, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            check_slot(rsp);
        if (stall_left == 0 && !calm_recv)
            stall_left = gap_len();
        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
            rsp_stall <= 1'b0;
    end

    // stimulus
    initial
    begin
        int i;
        int p;
        int n;
        setting_t s;
        kvsi_pkg::req_item_t it;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items
        for (i = 0; i < N_ROWS; i++)
        begin
            issue(rows[i].cmd);
            case (rows[i].kind)
                ROW_FIXED:   slot_queue.push_back(rows[i].want);
                ROW_PREDICT: compute_slots(rows[i].cmd);
                default: ;
            endcase
            pause();
        end
        wait_idle();

        // random items, one register setting per phase
        for (p = 0; p < N_PHASES; p++)
        begin
            if (p < N_FIXED_CFG)
                s = fixed_cfg[p];
            else
            begin
                s.win   = kvsi_pkg::CFG_DATA_W'($urandom_range(1, 32));
                s.ratio = kvsi_pkg::CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
                                                $urandom_range(100, 8191) :
                                                $urandom_range(1, 16));
                s.cap   = kvsi_pkg::CFG_DATA_W'($urandom_range(1, 32));
            end
            apply_setting(s);
            calm_send = (p == 1) || ($urandom_range(0, 3) == 0);
            calm_recv = (p == 1) || ($urandom_range(0, 3) == 0);
            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                it = pick_request();
                issue(it);
                compute_slots(it);
                if (it.req_type != REQ_UNUSED)
                    n++;
                if ($urandom_range(0, 39) == 0)
                    wait_idle();
                else
                    pause();
            end
            wait_idle();
        end

        $display("covered %0d requests (%0d ignored) over %0d register settings",
                 items_sent, items_ignored, N_PHASES + 1);
        $display("%0d results checked: %0d list entries, %0d error statuses",
                 results_seen, list_entries, error_results);
        if (mismatches == 0 && slot_queue.size() == 0)
            $display("kv_cache_slot_indexer test passed");
        else
            $display("kv_cache_slot_indexer test failed");
        $finish;
    end

    // run limit
    initial
    begin
        #25ms;
        $error("timeout with %0d results pending", slot_queue.size());
        $display("kv_cache_slot_indexer test failed");
        $finish;
    end

endmodule
